[rtl/lcs_pkg.sv]
package lcs_pkg;

  localparam int MAX_STEPS_DEF    = 64;
  localparam int MAX_FIXTURES_DEF = 64;
  localparam logic [16:0] Q16_ONE = 17'h10000;
  localparam logic [15:0] MS_PER_MINUTE = 16'd60000;

  localparam logic [2:0] REG_TIMING    = 3'd0;
  localparam logic [2:0] REG_DURATION  = 3'd1;
  localparam logic [2:0] REG_TEMPO     = 3'd2;
  localparam logic [2:0] REG_DIRECTION = 3'd3;
  localparam logic [2:0] REG_FADE      = 3'd4;
  localparam logic [2:0] REG_STEPS     = 3'd5;
  localparam logic [2:0] REG_FIXTURES  = 3'd6;
  localparam logic [2:0] REG_SEED      = 3'd7;

  localparam logic [1:0] TM_FIXED = 2'd0;
  localparam logic [1:0] TM_BPM   = 2'd1;
  localparam logic [1:0] TM_BEAT  = 2'd2;

  localparam logic [1:0] DIR_FWD    = 2'd0;
  localparam logic [1:0] DIR_BWD    = 2'd1;
  localparam logic [1:0] DIR_PING   = 2'd2;
  localparam logic [1:0] DIR_RANDOM = 2'd3;

  // controller commands to the datapath
  typedef struct packed {
    logic capture;     // latch request, update start/beat state
    logic div_start;   // load divider operands
    logic div_sel;     // which division to load
    logic div_step;    // one restoring step
    logic take_q1;     // step counter/phase from first division (counter from beat count in beat mode)
    logic take_q2;     // mix from second division
    logic offset_step; // one subtract step of offset reduction
    logic rng_step;    // random update
    logic fix_clear;   // restart fixture index
    logic fix_next;    // advance fixture index
  } lcs_cmd_t;

  typedef struct packed {
    logic skip;        // tick gives no results
    logic need_div2;   // fade is on
    logic offset_done; // offset reduction finished
    logic last_fix;    // fixture index is the final one
  } lcs_stat_t;

endpackage

[rtl/lcs_divider.sv]
module lcs_divider
  import lcs_pkg::*;
(
  input  logic        clk,
  input  logic        load,
  input  logic        step,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic [63:0] quot
);

  logic [63:0] q;
  logic [31:0] r;
  logic [31:0] d;
  logic [32:0] trial;

  always_comb begin
    trial = {r, q[63]} - {1'b0, d};
  end

  // restoring division, one quotient bit a cycle while step is high
  always_ff @(posedge clk) begin
    if (load) begin
      q <= dividend;
      r <= '0;
      d <= divisor;
    end else if (step) begin
      if (!trial[32] || r[31]) begin
        r <= trial[31:0];
        q <= {q[62:0], 1'b1};
      end else begin
        r <= {r[30:0], q[63]};
        q <= {q[62:0], 1'b0};
      end
    end
  end

  assign quot = q;

endmodule

[rtl/lcs_datapath.sv]
module lcs_datapath
  import lcs_pkg::*;
#(
  parameter int MAX_STEPS    = MAX_STEPS_DEF,
  parameter int MAX_FIXTURES = MAX_FIXTURES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic [31:0] time_ms,
  input  logic [15:0] beat_counter,
  input  lcs_cmd_t    cmd,
  output lcs_stat_t   stat,
  output logic [5:0]  fixture_slot,
  output logic [5:0]  current_step,
  output logic [5:0]  previous_step,
  output logic [16:0] fade_mix,
  output logic        fade_enabled,
  output logic        last_fixture
);

  localparam int SW = $clog2(MAX_STEPS + 1);
  localparam int FW = $clog2(MAX_FIXTURES + 1);
  localparam int OW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;

  logic [1:0]  timing_mode;
  logic [15:0] step_duration_ms;
  logic [9:0]  tempo_bpm;
  logic [1:0]  direction_mode;
  logic [16:0] fade_fraction;
  logic [6:0]  pattern_steps;
  logic [6:0]  fixture_total;
  logic [31:0] rng_state;

  logic [31:0] start_time;
  logic        started_flag;
  logic [15:0] previous_beat_count;
  logic [31:0] last_beat_time;
  logic        beat_seen;
  logic [31:0] beat_interval;
  logic [31:0] beat_steps;
  logic [31:0] last_step_counter;
  logic [OW-1:0] random_offset;
  logic        rnd_load;

  logic [31:0] now;
  logic [31:0] counter;
  logic [16:0] phase;
  logic [16:0] mix;
  logic [16:0] fade;
  logic [SW-1:0] n;
  logic [FW-1:0] nfix;
  logic [32:0] red;      // value being reduced mod n (or 2s)
  logic [SW:0]  modulus;
  logic [OW-1:0] offset;
  logic [FW-1:0] fix;
  logic [OW-1:0] cur;

  logic [63:0] div_a;
  logic [31:0] div_b;
  logic [63:0] quot;
  logic [31:0] rng_next;
  logic [31:0] x1, x2;
  logic [31:0] since;
  logic [SW:0] span;

  always_comb begin
    if (fixture_total > 7'(MAX_FIXTURES)) nfix = FW'(MAX_FIXTURES);
    else nfix = FW'(fixture_total);
    if (pattern_steps > 7'(MAX_STEPS)) n = SW'(MAX_STEPS);
    else n = SW'(pattern_steps);
    fade = (fade_fraction > Q16_ONE) ? Q16_ONE : fade_fraction;
    stat.skip = (fixture_total == '0) || (pattern_steps == '0);
    stat.need_div2 = (fade != '0);
    stat.last_fix = (fix == nfix - FW'(1));
    span = (n > SW'(1)) ? {1'b0, n} - (SW+1)'(1) : (SW+1)'(1);
    modulus = (direction_mode == DIR_PING) ? {span[SW-1:0], 1'b0} : {1'b0, n};
    stat.offset_done = (red < {{(33-SW-1){1'b0}}, modulus});
    since = now - last_beat_time;
    x1 = rng_state ^ (rng_state << 13);
    x2 = x1 ^ (x1 >> 17);
    rng_next = x2 ^ (x2 << 5);
    // fixed and bpm: quotient holds counter above 16 phase bits
    if (!cmd.div_sel) begin
      unique case (timing_mode)
        TM_BPM: begin
          div_a = ({32'd0, now - start_time}
                   * {54'd0, (tempo_bpm == '0) ? 10'd1 : tempo_bpm}) << 16;
          div_b = {16'd0, MS_PER_MINUTE};
        end
        TM_BEAT: begin
          div_a = {16'd0, since, 16'd0};
          div_b = beat_interval;
        end
        default: begin
          div_a = {16'd0, now - start_time, 16'd0};
          div_b = {16'd0, (step_duration_ms == '0) ? 16'd1 : step_duration_ms};
        end
      endcase
    end else begin
      div_a = {31'd0, phase, 16'd0};
      div_b = {15'd0, fade};
    end
  end

  lcs_divider u_div (
    .clk(clk), .load(cmd.div_start), .step(cmd.div_step),
    .dividend(div_a), .divisor(div_b), .quot(quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      timing_mode <= TM_FIXED;
      step_duration_ms <= 16'd500;
      tempo_bpm <= 10'd120;
      direction_mode <= DIR_FWD;
      fade_fraction <= '0;
      pattern_steps <= 7'd1;
      fixture_total <= 7'd1;
      rng_state <= 32'd1;
      start_time <= '0;
      started_flag <= 1'b0;
      previous_beat_count <= '0;
      last_beat_time <= '0;
      beat_seen <= 1'b0;
      beat_interval <= '0;
      beat_steps <= '0;
      last_step_counter <= '1;
      random_offset <= '0;
      rnd_load <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_TIMING:    timing_mode <= cfg_data[1:0];
          REG_DURATION:  step_duration_ms <= cfg_data[15:0];
          REG_TEMPO:     tempo_bpm <= cfg_data[9:0];
          REG_DIRECTION: direction_mode <= cfg_data[1:0];
          REG_FADE:      fade_fraction <= cfg_data[16:0];
          REG_STEPS:     pattern_steps <= cfg_data[6:0];
          REG_FIXTURES:  fixture_total <= cfg_data[6:0];
          REG_SEED:      rng_state <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.capture && fixture_total != '0) begin
        if (!started_flag) begin
          start_time <= time_ms;
          started_flag <= 1'b1;
        end
        if (pattern_steps != '0 && timing_mode == TM_BEAT
            && beat_counter != previous_beat_count) begin
          if (beat_seen) beat_interval <= time_ms - last_beat_time;
          last_beat_time <= time_ms;
          beat_seen <= 1'b1;
          previous_beat_count <= beat_counter;
          beat_steps <= beat_steps + 32'd1;
        end
      end
      if (cmd.rng_step && direction_mode == DIR_RANDOM) begin
        rnd_load <= (counter != last_step_counter);
        if (counter != last_step_counter) begin
          last_step_counter <= counter;
          rng_state <= rng_next;
        end
      end
      // keep the reduced offset only when a new random step was drawn
      if (cmd.fix_clear && direction_mode == DIR_RANDOM && rnd_load)
        random_offset <= offset;
    end
  end

  function automatic logic [5:0] shift_amt(input logic [32:0] v, input logic [SW:0] m);
    logic [5:0] s;
    s = '0;
    for (int k = 32; k >= 0; k--) begin
      if ((({{(33-SW-1){1'b0}}, m}) << k) <= v && s == '0 && k != 0
          && (({{(33-SW-1){1'b0}}, m} << k) >> k) == {{(33-SW-1){1'b0}}, m})
        s = 6'(k);
    end
    return s;
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.capture) now <= time_ms;
    if (cmd.take_q1) begin
      if (timing_mode == TM_BEAT) begin
        counter <= beat_steps;
        if (beat_seen && beat_interval != '0)
          phase <= (quot > 64'(Q16_ONE)) ? Q16_ONE : quot[16:0];
        else
          phase <= Q16_ONE;
        red <= {1'b0, beat_steps};
      end else begin
        counter <= quot[47:16];
        phase <= {1'b0, quot[15:0]};
        red <= {1'b0, quot[47:16]};
      end
    end
    if (cmd.take_q2) begin
      if (fade == '0) mix <= Q16_ONE;
      else mix <= (quot > 64'(Q16_ONE)) ? Q16_ONE : quot[16:0];
    end
    // random: reduce the fresh state instead of the counter on a new step, else the kept offset
    if (cmd.rng_step && direction_mode == DIR_RANDOM) begin
      if (counter != last_step_counter) red <= {1'b0, rng_next};
      else red <= {{(33-OW){1'b0}}, random_offset};
    end
    if (cmd.offset_step && !stat.offset_done) begin
      // subtract the largest shifted modulus that fits, one shift per cycle
      red <= red - ({{(33-SW-1){1'b0}}, modulus} << shift_amt(red, modulus));
    end
    if (cmd.fix_clear) begin
      fix <= '0;
      cur <= (SW'(offset) >= n) ? OW'(SW'(offset) - n) : offset;
    end else if (cmd.fix_next) begin
      fix <= fix + FW'(1);
      cur <= (SW'(cur) == n - SW'(1)) ? '0 : cur + OW'(1);
    end
  end

  always_comb begin
    logic [SW:0] p;
    p = red[SW:0];
    unique case (direction_mode)
      DIR_FWD:    offset = OW'(p);
      DIR_BWD:    offset = (p == '0) ? '0 : OW'({1'b0, n} - p);
      DIR_PING:   offset = (p <= span) ? OW'(p) : OW'({span[SW-1:0], 1'b0} - p);
      default:    offset = OW'(p);
    endcase
  end

  assign fixture_slot  = 6'(fix);
  assign current_step  = 6'(cur);
  assign previous_step = (cur == '0) ? 6'(n - SW'(1)) : 6'(cur - OW'(1));
  assign fade_mix      = mix;
  assign fade_enabled  = (fade != '0);
  assign last_fixture  = stat.last_fix;

endmodule

[rtl/lighting_chaser_step_sequencer_unit.sv]
// from request to first result: a restoring division for step counter and
// phase, offset reduction, and a second division for the fade mix only when
// fading is on; a new request waits until every result of the last is out
// results: one result a cycle while out_ready is high
// reset: synchronous active-high; registers take their defaults, state clears
module lighting_chaser_step_sequencer_unit
  import lcs_pkg::*;
#(
  parameter int MAX_STEPS    = MAX_STEPS_DEF,
  parameter int MAX_FIXTURES = MAX_FIXTURES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] time_ms,
  input  logic [15:0] beat_counter,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  fixture_slot,
  output logic [5:0]  current_step,
  output logic [5:0]  previous_step,
  output logic [16:0] fade_mix,
  output logic        fade_enabled,
  output logic        last_fixture
);

  lcs_cmd_t  cmd;
  lcs_stat_t stat;

  lcs_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .stat(stat), .cmd(cmd)
  );

  lcs_datapath #(.MAX_STEPS(MAX_STEPS), .MAX_FIXTURES(MAX_FIXTURES)) u_dp (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .time_ms(time_ms), .beat_counter(beat_counter),
    .cmd(cmd), .stat(stat), .fixture_slot(fixture_slot),
    .current_step(current_step), .previous_step(previous_step),
    .fade_mix(fade_mix), .fade_enabled(fade_enabled), .last_fixture(last_fixture)
  );

endmodule

[rtl/lcs_ctrl.sv]
module lcs_ctrl
  import lcs_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  lcs_stat_t stat,
  output lcs_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_LOAD1, S_DIV1, S_TAKE1, S_RNG, S_RED,
    S_LOAD2, S_DIV2, S_TAKE2, S_EMIT
  } state_t;

  state_t state;
  logic [5:0] cnt;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE:  cmd.capture = in_valid;
      S_LOAD1: cmd.div_start = 1'b1;
      S_DIV1:  cmd.div_step = 1'b1;
      S_TAKE1: cmd.take_q1 = 1'b1;
      S_RNG:   cmd.rng_step = 1'b1;
      S_RED:   cmd.offset_step = 1'b1;
      S_LOAD2: begin cmd.div_start = 1'b1; cmd.div_sel = 1'b1; end
      S_DIV2:  begin cmd.div_step = 1'b1; cmd.div_sel = 1'b1; end
      S_TAKE2: begin cmd.take_q2 = 1'b1; cmd.fix_clear = 1'b1; end
      S_EMIT:  cmd.fix_next = out_ready && !stat.last_fix;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      cnt <= '0;
    end else begin
      unique case (state)
        S_IDLE:  if (in_valid) state <= S_CHECK;
        S_CHECK: state <= stat.skip ? S_IDLE : S_LOAD1;
        S_LOAD1: begin cnt <= '0; state <= S_DIV1; end
        S_DIV1: begin
          cnt <= cnt + 6'd1;
          if (cnt == 6'd63) state <= S_TAKE1;
        end
        S_TAKE1: state <= S_RNG;
        S_RNG:   state <= S_RED;
        // no fade division when fading is off
        S_RED:   if (stat.offset_done) state <= stat.need_div2 ? S_LOAD2 : S_TAKE2;
        S_LOAD2: begin cnt <= '0; state <= S_DIV2; end
        S_DIV2: begin
          cnt <= cnt + 6'd1;
          if (cnt == 6'd63) state <= S_TAKE2;
        end
        S_TAKE2: begin out_valid <= 1'b1; state <= S_EMIT; end
        S_EMIT: if (out_ready && stat.last_fix) begin
          out_valid <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[bench/tb_top.sv]
module tb_top
  import lcs_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [5:0]  slot;
    logic [5:0]  cur;
    logic [5:0]  prev;
    logic [16:0] mix;
    logic        fade_on;
    logic        last;
  } fixture_res_t;

  class chase_scoreboard;
    fixture_res_t pending[$];
    int errors;
    // shadow registers
    logic [1:0]  timing;
    logic [15:0] dur;
    logic [9:0]  bpm;
    logic [1:0]  dir;
    logic [16:0] fade;
    logic [6:0]  nsteps;
    logic [6:0]  nfix;
    logic [31:0] seed;
    // shadow state
    logic [31:0] t0;
    logic        started;
    logic [15:0] prev_beats;
    logic [31:0] beat_time;
    logic        beat_valid;
    logic [31:0] beat_gap;
    logic [31:0] beat_count;
    logic [31:0] last_counter;
    logic [5:0]  rnd_off;
    logic [31:0] rng;

    function void reset_state();
      timing = TM_FIXED; dur = 500; bpm = 120; dir = DIR_FWD; fade = 0;
      nsteps = 1; nfix = 1; seed = 1;
      t0 = 0; started = 0; prev_beats = 0; beat_time = 0; beat_valid = 0;
      beat_gap = 0; beat_count = 0; last_counter = '1; rnd_off = 0; rng = 1;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        REG_TIMING:    timing = val[1:0];
        REG_DURATION:  dur = val[15:0];
        REG_TEMPO:     bpm = val[9:0];
        REG_DIRECTION: dir = val[1:0];
        REG_FADE:      fade = val[16:0];
        REG_STEPS:     nsteps = val[6:0];
        REG_FIXTURES:  nfix = val[6:0];
        default: begin
          seed = val; rng = val;
        end
      endcase
    endfunction

    function void note_request(logic [31:0] now, logic [15:0] beats);
      int unsigned fx, n, offset, span, pos, f, cur;
      logic [31:0] counter;
      logic [63:0] e, num, den, ph, m, mix;
      fixture_res_t r;
      if (nfix == 0) return;
      fx = (nfix > 64) ? 64 : nfix;
      if (!started) begin
        t0 = now; started = 1;
      end
      if (nsteps == 0) return;
      n = (nsteps > 64) ? 64 : nsteps;
      if (timing == TM_BEAT) begin
        if (beats != prev_beats) begin
          if (beat_valid) beat_gap = now - beat_time;
          beat_time = now; beat_valid = 1; prev_beats = beats;
          beat_count = beat_count + 1;
        end
        counter = beat_count;
        if (beat_valid && beat_gap != 0) begin
          e = 64'(32'(now - beat_time));
          ph = (e * 65536) / beat_gap;
          if (ph > 65536) ph = 65536;
        end else ph = 65536;
      end else begin
        e = 64'(32'(now - t0));
        if (timing == TM_BPM) begin
          num = 60000; den = (bpm != 0) ? bpm : 1;
        end else begin
          num = (dur != 0) ? dur : 1; den = 1;
        end
        counter = 32'((e * den) / num);
        ph = (((e * den) % num) * 65536) / num;
      end
      case (dir)
        DIR_FWD: offset = counter % n;
        DIR_BWD: offset = (n - counter % n) % n;
        DIR_PING: begin
          span = (n > 1) ? n - 1 : 1;
          pos = counter % (2 * span);
          offset = (pos <= span) ? pos : 2 * span - pos;
        end
        default: begin
          if (counter != last_counter) begin
            last_counter = counter;
            rng ^= rng << 13; rng ^= rng >> 17; rng ^= rng << 5;
            rnd_off = 6'(rng % n);
          end
          offset = rnd_off;
        end
      endcase
      f = (fade > 65536) ? 65536 : fade;
      if (f == 0) mix = 65536;
      else begin
        m = (ph * 65536) / f;
        mix = (m > 65536) ? 65536 : m;
      end
      for (int i = 0; i < fx; i++) begin
        cur = (i + offset) % n;
        r.slot = 6'(i); r.cur = 6'(cur); r.prev = 6'((cur + n - 1) % n);
        r.mix = mix[16:0]; r.fade_on = (f != 0); r.last = (i + 1 == fx);
        pending.push_back(r);
      end
    endfunction

    function void check_result(fixture_res_t got);
      fixture_res_t exp;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", got);
        return;
      end
      exp = pending.pop_front();
      if (got !== exp) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %p, got %p", exp, got);
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic cfg_we = 0;
  logic [2:0] cfg_index = 0;
  logic [31:0] cfg_data = 0;
  logic in_valid = 0, in_ready;
  logic [31:0] time_ms = 0;
  logic [15:0] beat_counter = 0;
  logic out_valid, out_ready = 0;
  logic [5:0] fixture_slot, current_step, previous_step;
  logic [16:0] fade_mix;
  logic fade_enabled, last_fixture;

  chase_scoreboard sb = new();
  logic [31:0] clock_ms;
  logic [15:0] beat_num;
  bit hold_rx = 0;
  bit stim_done = 0;

  lighting_chaser_step_sequencer_unit i_dut (.*);

  always #10 clk = ~clk;

  function automatic int pick_gap();
    return ($urandom_range(0, 9) < 7) ? $urandom_range(0, 2) : $urandom_range(5, 60);
  endfunction

  // registers change only while the block is idle and no result is owed
  task automatic set_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    while (!in_ready || sb.pending.size() != 0) @(negedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_we <= 0;
  endtask

  task automatic send_tick(logic [31:0] t, logic [15:0] b, bit gaps);
    int g;
    g = gaps ? pick_gap() : 0;
    repeat (g + 1) @(negedge clk);
    in_valid <= 1; time_ms <= t; beat_counter <= b;
    do @(posedge clk); while (!in_ready);
    sb.note_request(t, b);
    @(negedge clk);
    in_valid <= 0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic advance(bit beat_tick);
    int r;
    r = $urandom_range(0, 9);
    clock_ms += (r < 8) ? $urandom_range(0, 400) : $urandom();
    if (beat_tick || $urandom_range(0, 2) == 0)
      beat_num += (r == 9) ? 16'($urandom()) : 16'd1;
  endtask

  // result side
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result({fixture_slot, current_step, previous_step, fade_mix,
                       fade_enabled, last_fixture});
  end

  initial begin
    forever begin
      @(negedge clk);
      if (hold_rx) out_ready <= 0;
      else if (stim_done || $urandom_range(0, 3) != 0) out_ready <= 1;
      else out_ready <= ($urandom_range(0, 4) == 0);
    end
  end

  initial begin
    #50ms;
    $display("FAILURE");
    $finish;
  end

  initial begin
    int nphase;
    sb.reset_state();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    clock_ms = 0; beat_num = 0;

    // directed: defaults, extremes of time and beats
    send_tick(32'h0, 16'h0, 0);
    send_tick(32'hFFFF_FFFF, 16'hFFFF, 0);
    set_reg(REG_FIXTURES, 64);
    set_reg(REG_STEPS, 64);
    set_reg(REG_FADE, 65536);
    send_tick(32'h8000_0000, 16'h8000, 0);
    for (int d = 0; d < 4; d++) begin
      set_reg(REG_DIRECTION, d);
      for (int tm = 0; tm < 3; tm++) begin
        set_reg(REG_TIMING, tm);
        send_tick(32'h1234 * (d + 1) * (tm + 3), 16'h5 + tm, 0);
      end
    end
    drain();
    // zero fixtures, empty pattern, oversize counts, zero seed, duration and tempo, zero and oversize fade
    set_reg(REG_FIXTURES, 0);
    send_tick(32'd77, 16'd1, 0);
    set_reg(REG_FIXTURES, 127);
    set_reg(REG_STEPS, 0);
    send_tick(32'd99, 16'd2, 0);
    set_reg(REG_STEPS, 127);
    set_reg(REG_SEED, 0);
    set_reg(REG_DURATION, 0);
    set_reg(REG_TEMPO, 0);
    set_reg(REG_FADE, 0);
    send_tick(32'd5000, 16'd3, 0);
    set_reg(REG_TIMING, 3);
    send_tick(32'd6000, 16'd3, 0);
    set_reg(REG_FADE, 131071);
    send_tick(32'hFFFF_FFF0, 16'd9, 0);
    drain();

    // long receiver hold while requests keep coming
    set_reg(REG_FIXTURES, 64);
    hold_rx = 1;
    fork
      begin
        repeat (600) @(negedge clk);
        hold_rx = 0;
      end
      for (int k = 0; k < 4; k++) begin
        advance(1); send_tick(clock_ms, beat_num, 0);
      end
    join
    drain();

    // random phases
    for (nphase = 0; nphase < 30; nphase++) begin
      set_reg(REG_TIMING, $urandom_range(0, 3));
      set_reg(REG_DURATION, ($urandom_range(0, 4) == 0) ? $urandom() : $urandom_range(1, 600));
      set_reg(REG_TEMPO, ($urandom_range(0, 4) == 0) ? $urandom() : $urandom_range(1, 300));
      set_reg(REG_DIRECTION, $urandom_range(0, 3));
      set_reg(REG_FADE, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 131071)
                                                    : $urandom_range(0, 65536));
      set_reg(REG_STEPS, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
                                                     : $urandom_range(1, 64));
      set_reg(REG_FIXTURES, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
                                                        : $urandom_range(1, 16));
      if ($urandom_range(0, 2) == 0) set_reg(REG_SEED, $urandom());
      for (int k = 0; k < 15; k++) begin
        advance($urandom_range(0, 1));
        send_tick(clock_ms, beat_num, 1);
      end
      drain();
    end

    stim_done = 1;
    drain();
    if (sb.errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule

[files.f]
rtl/lcs_pkg.sv
rtl/lcs_divider.sv
rtl/lcs_datapath.sv
rtl/lighting_chaser_step_sequencer_unit.sv
rtl/lcs_ctrl.sv
bench/tb_top.sv
